// ===== rtl/core/cfdo_pkg.sv =====
// Shared types, constants and helper functions of the CAN frame odometry block.
`timescale 1ns / 1ps

package cfdo_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_TIME_BITS     = 48;
    localparam int DEF_VEL_FRAC_BITS = 16;

    // Width of the wide product and dividend path.
    localparam int NUM_W = 128;

    // Microseconds per second, used as a multiplier.
    localparam logic [31:0] US_PER_S = 32'd1000000;

    // Counts beyond these bounds re-baseline the odometry.
    localparam logic signed [31:0] NEAR_HI = 32'sd2146483647;
    localparam logic signed [31:0] NEAR_LO = -32'sd2146483648;

    // Configuration register indexes.
    localparam logic [3:0] REG_MOTOR_ID   = 4'd0;
    localparam logic [3:0] REG_FAULT_ID   = 4'd1;
    localparam logic [3:0] REG_DIR_FLIP   = 4'd2;
    localparam logic [3:0] REG_MPC        = 4'd3;
    localparam logic [3:0] REG_IWB        = 4'd4;
    localparam logic [3:0] REG_MAX_DELTA  = 4'd5;
    localparam logic [3:0] REG_MIN_INT    = 4'd6;
    localparam logic [3:0] REG_SPEED_THR  = 4'd7;

    // Reset values of the configuration registers.
    localparam logic [28:0] RST_MOTOR_ID  = 29'd402776067;
    localparam logic [28:0] RST_FAULT_ID  = 29'd402776066;
    localparam logic [1:0]  RST_DIR_FLIP  = 2'd0;
    localparam logic [31:0] RST_MPC       = 32'd0;
    localparam logic [31:0] RST_IWB       = 32'd65536;
    localparam logic [30:0] RST_MAX_DELTA = 31'h7FFFFFFF;
    localparam logic [19:0] RST_MIN_INT   = 20'd1000;
    localparam logic [30:0] RST_SPEED_THR = 31'd655;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_SHORT   = 3'd1,
        KIND_BASE    = 3'd2,
        KIND_SOON    = 3'd3,
        KIND_JUMP    = 3'd4,
        KIND_UPDATED = 3'd5,
        KIND_FAULT   = 3'd6
    } t_kind;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLASSIFY,
        OP_XLOAD_MS,
        OP_XLOAD_MD,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_FINISH,
        OP_OUT
    } t_op;

    // Second operand of the shared multiplier.
    typedef enum logic [1:0] {
        MS_MPC,
        MS_MEGA,
        MS_IWB
    } t_mul_src;

    // Command from controller to datapath.
    typedef struct packed {
        t_op        op;
        t_mul_src   mul_src;
        logic [1:0] chunk;
        logic       last;
        logic       first;
        logic       ang;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        t_kind kind;
        logic  out_busy;
    } t_stat;

    // Input request payload.
    typedef struct packed {
        logic [28:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] payload;
        logic [47:0] arrival_time_us;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [2:0]         result_kind;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] lin_speed;
        logic signed [31:0] yaw_rate;
        logic               moving;
        logic [31:0]        fault_word;
        logic               fault_changed;
    } t_out_item;

    // True when a count lies close to either 32-bit limit.
    function automatic logic near_limit(input logic [31:0] v);
        logic signed [31:0] s;
        s = $signed(v);
        return (s > NEAR_HI) || (s < NEAR_LO);
    endfunction

    // Magnitude of a two's complement 32-bit word, minimum maps to itself.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// ===== rtl/core/cfdo_ctrl.sv =====
// Controller state machine that sequences the odometry datapath.
`timescale 1ns / 1ps

module cfdo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cfdo_pkg::t_stat i_stat,
    output cfdo_pkg::t_cmd  o_cmd
);
    import cfdo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASSIFY,
        S_LOAD_MS,
        S_MUL,
        S_LOAD_MD,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_FINISH,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_idx, n_idx;
    logic       r_ang, n_ang;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_ang         = r_ang;
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.mul_src = MS_MPC;
        o_cmd.chunk   = r_cnt[1:0];
        o_cmd.last    = (r_cnt[1:0] == 2'd3);
        o_cmd.first   = (r_cnt == 5'd0);
        o_cmd.ang     = r_ang;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.op = OP_CLASSIFY;
                n_state  = (i_stat.kind == KIND_UPDATED) ? S_LOAD_MS : S_OUT;
            end
            S_LOAD_MS: begin
                o_cmd.op = OP_XLOAD_MS;
                n_idx    = 3'd0;
                n_cnt    = 5'd0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL_STEP;
                case (r_idx)
                    3'd0:    o_cmd.mul_src = MS_MPC;
                    3'd1:    o_cmd.mul_src = MS_MEGA;
                    3'd2:    o_cmd.mul_src = MS_MPC;
                    3'd3:    o_cmd.mul_src = MS_IWB;
                    default: o_cmd.mul_src = MS_MEGA;
                endcase
                n_cnt = r_cnt + 5'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt = 5'd0;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd1) begin
                        n_state = S_LOAD_MD;
                    end else if (r_idx == 3'd4) begin
                        n_ang   = 1'b0;
                        n_state = S_DIV_INIT;
                    end
                end
            end
            S_LOAD_MD: begin
                o_cmd.op = OP_XLOAD_MD;
                n_state  = S_MUL;
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = 5'd0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.op = OP_DIV_END;
                if (!r_ang) begin
                    n_ang   = 1'b1;
                    n_state = S_DIV_INIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
            r_idx   <= 3'd0;
            r_ang   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ang   <= n_ang;
        end
    end

endmodule

// ===== rtl/core/cfdo_dp.sv =====
// Datapath: configuration registers, odometry state, shared multiplier and divider.
`timescale 1ns / 1ps

module cfdo_dp #(
    parameter int TIME_BITS     = cfdo_pkg::DEF_TIME_BITS,
    parameter int VEL_FRAC_BITS = cfdo_pkg::DEF_VEL_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [3:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  cfdo_pkg::t_in_item  i_in,
    output cfdo_pkg::t_out_item o_out,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  cfdo_pkg::t_cmd      i_cmd,
    output cfdo_pkg::t_stat     o_stat
);
    import cfdo_pkg::*;

    localparam int DEN_W  = TIME_BITS + 72;
    localparam int CMP_W  = (DEN_W > NUM_W) ? DEN_W : NUM_W;
    localparam int LIN_SH = 33 - VEL_FRAC_BITS + 31;
    localparam int ANG_SH = 48 - VEL_FRAC_BITS + 31;

    // Configuration registers.
    logic [28:0] r_motor_id, r_fault_id;
    logic [1:0]  r_dir_flip;
    logic [31:0] r_mpc, r_iwb;
    logic [30:0] r_max_delta, r_speed_thr;
    logic [19:0] r_min_int;

    // Odometry state.
    logic [31:0]          r_base_left, r_base_right, r_cur_left, r_cur_right;
    logic [TIME_BITS-1:0] r_base_time;
    logic [31:0]          r_lin, r_ang, r_fault;
    logic                 r_moving;

    // Per-request working registers.
    t_in_item             r_in;
    t_kind                r_kind;
    logic                 r_changed;
    logic [32:0]          r_ms, r_md;
    logic                 r_sneg, r_dneg;
    logic [TIME_BITS-1:0] r_dt, r_now;
    logic [NUM_W-1:0]     r_x, r_acc, r_nl;
    logic [CMP_W-1:0]     r_rem, r_den;
    logic [30:0]          r_q;
    logic                 r_sat;
    t_out_item            r_out;
    logic                 r_out_valid;

    // Classification of the captured frame.
    logic [31:0]          cl, cr, dl, dr;
    logic [63:0]          now64;
    logic [TIME_BITS-1:0] now, dt;
    logic                 is_motor, is_fault, is_short, near, too_soon, jump;
    logic signed [33:0]   sum, dif;
    t_kind                kind;

    always_comb begin
        cl       = r_dir_flip[0] ? (32'd0 - r_in.payload[63:32]) : r_in.payload[63:32];
        cr       = r_dir_flip[1] ? (32'd0 - r_in.payload[31:0]) : r_in.payload[31:0];
        now64    = 64'(r_in.arrival_time_us);
        now      = now64[TIME_BITS-1:0];
        dt       = now - r_base_time;
        is_motor = (r_in.frame_id == r_motor_id);
        is_fault = !is_motor && (r_in.frame_id == r_fault_id);
        is_short = (r_in.frame_len < 4'd8);
        near     = near_limit(cl) || near_limit(cr);
        too_soon = (dt == '0) || (dt < TIME_BITS'(r_min_int));
        dl       = cl - r_base_left;
        dr       = cr - r_base_right;
        jump     = (mag32(dl) > 32'(r_max_delta)) || (mag32(dr) > 32'(r_max_delta));
        sum      = 34'($signed(dl)) + 34'($signed(dr));
        dif      = 34'($signed(dr)) - 34'($signed(dl));
        if (is_motor) begin
            if (is_short)      kind = KIND_SHORT;
            else if (near)     kind = KIND_BASE;
            else if (too_soon) kind = KIND_SOON;
            else if (jump)     kind = KIND_JUMP;
            else               kind = KIND_UPDATED;
        end else if (is_fault) begin
            kind = is_short ? KIND_SHORT : KIND_FAULT;
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    // Shared 32x32 multiplier, one 32-bit chunk of the wide operand per cycle.
    logic [31:0]      mul_b, chunk_v;
    logic [63:0]      prod;
    logic [NUM_W-1:0] acc_nx;

    always_comb begin
        case (i_cmd.mul_src)
            MS_MPC:  mul_b = r_mpc;
            MS_IWB:  mul_b = r_iwb;
            default: mul_b = US_PER_S;
        endcase
        chunk_v = r_x[{i_cmd.chunk, 5'b0} +: 32];
        prod    = 64'(chunk_v) * 64'(mul_b);
        acc_nx  = r_acc + (NUM_W'(prod) << {i_cmd.chunk, 5'b0});
    end

    // Restoring divider step and saturated signed result.
    logic             ge, neg;
    logic [31:0]      qv;
    logic [CMP_W-1:0] den_init;

    always_comb begin
        ge       = (r_rem >= r_den);
        neg      = i_cmd.ang ? r_dneg : r_sneg;
        den_init = CMP_W'(r_dt) << (i_cmd.ang ? ANG_SH : LIN_SH);
        if (r_sat) qv = neg ? 32'h80000000 : 32'h7FFFFFFF;
        else       qv = neg ? (32'd0 - 32'(r_q)) : 32'(r_q);
    end

    assign o_stat.kind     = kind;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out           = r_out;
    assign o_out_valid     = r_out_valid;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id  <= RST_MOTOR_ID;
            r_fault_id  <= RST_FAULT_ID;
            r_dir_flip  <= RST_DIR_FLIP;
            r_mpc       <= RST_MPC;
            r_iwb       <= RST_IWB;
            r_max_delta <= RST_MAX_DELTA;
            r_min_int   <= RST_MIN_INT;
            r_speed_thr <= RST_SPEED_THR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MOTOR_ID:  r_motor_id  <= i_cfg_data[28:0];
                REG_FAULT_ID:  r_fault_id  <= i_cfg_data[28:0];
                REG_DIR_FLIP:  r_dir_flip  <= i_cfg_data[1:0];
                REG_MPC:       r_mpc       <= i_cfg_data;
                REG_IWB:       r_iwb       <= i_cfg_data;
                REG_MAX_DELTA: r_max_delta <= i_cfg_data[30:0];
                REG_MIN_INT:   r_min_int   <= i_cfg_data[19:0];
                REG_SPEED_THR: r_speed_thr <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Odometry state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_left  <= '0;
            r_base_right <= '0;
            r_base_time  <= '0;
            r_cur_left   <= '0;
            r_cur_right  <= '0;
            r_lin        <= '0;
            r_ang        <= '0;
            r_fault      <= '0;
            r_moving     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // A new result is loaded only once the old one is gone or leaving.
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLASSIFY: begin
                    if (is_motor && !is_short) begin
                        r_cur_left  <= cl;
                        r_cur_right <= cr;
                        if (near) begin
                            r_base_left  <= cl;
                            r_base_right <= cr;
                            r_base_time  <= now;
                        end
                    end
                    if (is_fault && !is_short) begin
                        r_fault <= r_in.payload[31:0];
                    end
                end
                OP_DIV_END: begin
                    if (i_cmd.ang) r_ang <= qv;
                    else           r_lin <= qv;
                end
                OP_FINISH: begin
                    r_moving     <= (mag32(r_lin) > 32'(r_speed_thr))
                                 || (mag32(r_ang) > 32'(r_speed_thr));
                    r_base_left  <= r_cur_left;
                    r_base_right <= r_cur_right;
                    r_base_time  <= r_now;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_in <= i_in;
            end
            OP_CLASSIFY: begin
                r_kind    <= kind;
                r_changed <= is_fault && !is_short && (r_in.payload[31:0] != r_fault);
                r_ms      <= sum[33] ? 33'(-sum) : sum[32:0];
                r_md      <= dif[33] ? 33'(-dif) : dif[32:0];
                r_sneg    <= sum[33];
                r_dneg    <= dif[33];
                r_dt      <= dt;
                r_now     <= now;
            end
            OP_XLOAD_MS: begin
                r_x   <= NUM_W'(r_ms);
                r_acc <= '0;
            end
            OP_XLOAD_MD: begin
                r_nl  <= r_x;
                r_x   <= NUM_W'(r_md);
                r_acc <= '0;
            end
            OP_MUL_STEP: begin
                if (i_cmd.last) begin
                    r_x   <= acc_nx;
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_nx;
                end
            end
            OP_DIV_INIT: begin
                r_rem <= CMP_W'(i_cmd.ang ? r_x : r_nl);
                r_den <= den_init;
            end
            OP_DIV_STEP: begin
                if (i_cmd.first) begin
                    r_sat <= ge;
                end else begin
                    r_q <= {r_q[29:0], ge};
                    if (ge) r_rem <= r_rem - r_den;
                end
                r_den <= r_den >> 1;
            end
            OP_OUT: begin
                r_out.result_kind   <= r_kind;
                r_out.left_count    <= $signed(r_cur_left);
                r_out.right_count   <= $signed(r_cur_right);
                r_out.lin_speed     <= $signed(r_lin);
                r_out.yaw_rate      <= $signed(r_ang);
                r_out.moving        <= r_moving;
                r_out.fault_word    <= r_fault;
                r_out.fault_changed <= r_changed;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/can_frame_differential_odometry.sv =====
// Top level of the CAN frame differential-drive odometry block.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in  (t_in_item)
// result    out        o_out_valid / i_out_ready    o_out (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A frame that computes velocity runs, from acceptance to result, five
// wide products of four 32x32 steps each on the shared multiplier, then two
// restoring divisions of 32 steps each. Every other frame goes straight to output.
// Reset is synchronous and active low; all but the working registers are reset.
// One request is processed at a time; a pending result waits in the output
// register while the next request is accepted, and stalls the controller only
// when a new result is ready before the old one is taken.
`timescale 1ns / 1ps

module can_frame_differential_odometry #(
    parameter int TIME_BITS     = cfdo_pkg::DEF_TIME_BITS,
    parameter int VEL_FRAC_BITS = cfdo_pkg::DEF_VEL_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cfdo_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cfdo_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import cfdo_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    cfdo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    cfdo_dp #(
        .TIME_BITS     (TIME_BITS),
        .VEL_FRAC_BITS (VEL_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
